[rtl/crc16frc_pkg.sv]
`default_nettype none
package crc16frc_pkg;

  localparam int unsigned MAX_FRAME   = 64;
  // Frame size limit, clamped so the payload fits the length field and the store
  localparam int unsigned FRAME_LIMIT = (MAX_FRAME < 67) ? MAX_FRAME : 67;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned PLEN_W      = 6;
  localparam int unsigned HDR_BYTES   = 2;
  localparam int unsigned OVH_BYTES   = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef logic [1:0]        cfg_idx_t;
  typedef logic [2:0]        verdict_t;
  typedef logic [PLEN_W-1:0] plen_t;

  localparam cfg_idx_t CFG_OWN_ADDRESS     = 2'd0;
  localparam cfg_idx_t CFG_RESPONSE_OPCODE = 2'd1;
  localparam cfg_idx_t CFG_DELIVERY_EN     = 2'd2;

  localparam verdict_t VERDICT_OK          = 3'd0;
  localparam verdict_t VERDICT_SHORT       = 3'd1;
  localparam verdict_t VERDICT_OPCODE      = 3'd2;
  localparam verdict_t VERDICT_ADDRESS     = 3'd3;
  localparam verdict_t VERDICT_CRC         = 3'd4;
  localparam verdict_t VERDICT_TOO_LONG    = 3'd5;
  localparam verdict_t VERDICT_NO_RECEIVER = 3'd6;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // One byte of reflected CRC-16, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage
`default_nettype wire

[rtl/crc16_frame_receive_checker.sv]
`default_nettype none
// Framed packet receive checker. Takes one frame byte per cycle while the
// output is not stalled (address, opcode, payload, CRC low, CRC high;
// frame_end_i on the final byte), runs a reflected CRC-16 over all but the
// trailing two bytes and writes payload bytes into a 64 x 8 synchronous
// store. The final byte produces a summary transfer with a verdict; an
// accepted frame with P payload bytes is followed by P payload transfers
// read back from the store, the final one marked last. After a frame end
// the input stalls while the store drains through its single read port.
// The user must write registers only while idle; the block does not enforce it.
module crc16_frame_receive_checker (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire crc16frc_pkg::cfg_idx_t   cfg_idx_i,
  input  wire logic [7:0]               cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [7:0]               rx_byte_i,
  input  wire logic                     frame_end_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          kind_o,
  output crc16frc_pkg::verdict_t        verdict_o,
  output crc16frc_pkg::plen_t           frame_len_o,
  output logic [7:0]                    data_o,
  output logic                          last_o
);
  import crc16frc_pkg::*;

  localparam logic S_RX    = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic [7:0] own_addr_q, resp_op_q;
  logic       deliv_en_q;

  logic             state_q, state_d;
  logic [15:0]      crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       dest_q, dest_d, op_q, op_d;
  logic [15:0]      hb_q, hb_d;
  logic             ovf_q, ovf_d;

  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rd_data_q;
  logic             rd_pend_q, rd_pend_d;
  plen_t            rd_ptr_q, rd_ptr_d;
  plen_t            ld_cnt_q, ld_cnt_d;
  plen_t            plen_q, plen_d;

  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  verdict_t         verdict_q, verdict_d;
  plen_t            olen_q, olen_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;

  logic             out_ready, in_acc, frame_done, load_out, issue, wr_en;
  logic [CNT_W-1:0] wr_off;
  logic [15:0]      crc_upd, hb_nx, rec;
  logic [CNT_W-1:0] cnt_nx;
  logic [7:0]       dest_nx, op_nx;
  logic             ovf_nx;
  verdict_t         verdict;
  plen_t            plen;
  logic             pay_last;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_RX) || !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign frame_done = in_acc && frame_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      resp_op_q  <= '0;
      deliv_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_ADDRESS:     own_addr_q <= cfg_data_i;
        CFG_RESPONSE_OPCODE: resp_op_q  <= cfg_data_i;
        CFG_DELIVERY_EN:     deliv_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Per-byte frame update and verdict on the final byte
  always_comb begin
    crc_upd = (cnt_q >= CNT_W'(HDR_BYTES)) ? crc_byte(crc_q, hb_q[15:8]) : crc_q;
    hb_nx   = {hb_q[7:0], rx_byte_i};
    cnt_nx  = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
    dest_nx = (cnt_q == '0) ? rx_byte_i : dest_q;
    op_nx   = (cnt_q == CNT_W'(1)) ? rx_byte_i : op_q;
    ovf_nx  = ovf_q || (cnt_q == CNT_MAX) || (cnt_q >= CNT_W'(FRAME_LIMIT));
    rec     = {hb_nx[7:0], hb_nx[15:8]};
    wr_off  = cnt_q - CNT_W'(OVH_BYTES);
    wr_en   = in_acc && (cnt_q >= CNT_W'(OVH_BYTES)) && (wr_off < CNT_W'(STORE_DEPTH));

    if (cnt_nx < CNT_W'(OVH_BYTES))  verdict = VERDICT_SHORT;
    else if (op_nx != resp_op_q)     verdict = VERDICT_OPCODE;
    else if (dest_nx != own_addr_q)  verdict = VERDICT_ADDRESS;
    else if (rec != crc_upd)         verdict = VERDICT_CRC;
    else if (ovf_nx)                 verdict = VERDICT_TOO_LONG;
    else if (!deliv_en_q)            verdict = VERDICT_NO_RECEIVER;
    else                             verdict = VERDICT_OK;

    plen = '0;
    if (verdict == VERDICT_OK) begin
      plen = PLEN_W'(cnt_nx - CNT_W'(OVH_BYTES));
    end
  end

  // Drain: read one entry ahead, hold read data until the output takes it
  assign load_out = (state_q == S_DRAIN) && rd_pend_q && out_ready;
  assign issue    = (state_q == S_DRAIN) && (rd_ptr_q != plen_q) && (!rd_pend_q || load_out);
  assign pay_last = (ld_cnt_q + 1'b1) == plen_q;

  always_comb begin
    state_d     = state_q;
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    dest_d      = dest_q;
    op_d        = op_q;
    hb_d        = hb_q;
    ovf_d       = ovf_q;
    rd_pend_d   = rd_pend_q;
    rd_ptr_d    = rd_ptr_q;
    ld_cnt_d    = ld_cnt_q;
    plen_d      = plen_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    verdict_d   = verdict_q;
    olen_d      = olen_q;
    data_d      = data_q;
    last_d      = last_q;

    unique case (state_q)
      S_RX: begin
        if (in_acc) begin
          crc_d  = crc_upd;
          cnt_d  = cnt_nx;
          dest_d = dest_nx;
          op_d   = op_nx;
          hb_d   = hb_nx;
          ovf_d  = ovf_nx;
        end
        if (frame_done) begin
          crc_d       = CRC_INIT;
          cnt_d       = '0;
          dest_d      = '0;
          op_d        = '0;
          hb_d        = '0;
          ovf_d       = 1'b0;
          out_valid_d = 1'b1;
          kind_d      = KIND_SUMMARY;
          verdict_d   = verdict;
          olen_d      = plen;
          data_d      = '0;
          last_d      = (plen == '0);
          plen_d      = plen;
          rd_ptr_d    = '0;
          ld_cnt_d    = '0;
          rd_pend_d   = 1'b0;
          if (plen != '0) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (issue) begin
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (issue) begin
          rd_pend_d = 1'b1;
        end else if (load_out) begin
          rd_pend_d = 1'b0;
        end
        if (load_out) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_PAYLOAD;
          verdict_d   = VERDICT_OK;
          olen_d      = plen_q;
          data_d      = rd_data_q;
          last_d      = pay_last;
          ld_cnt_d    = ld_cnt_q + 1'b1;
          if (pay_last) begin
            state_d = S_RX;
          end
        end
      end
      default: state_d = S_RX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RX;
      crc_q       <= CRC_INIT;
      cnt_q       <= '0;
      dest_q      <= '0;
      op_q        <= '0;
      hb_q        <= '0;
      ovf_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_ptr_q    <= '0;
      ld_cnt_q    <= '0;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      crc_q       <= crc_d;
      cnt_q       <= cnt_d;
      dest_q      <= dest_d;
      op_q        <= op_d;
      hb_q        <= hb_d;
      ovf_q       <= ovf_d;
      rd_pend_q   <= rd_pend_d;
      rd_ptr_q    <= rd_ptr_d;
      ld_cnt_q    <= ld_cnt_d;
      plen_q      <= plen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    verdict_q <= verdict_d;
    olen_q    <= olen_d;
    data_q    <= data_d;
    last_q    <= last_d;
  end

  // Payload store: writes only while receiving, reads only while draining
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_off[STORE_AW-1:0]] <= hb_q[15:8];
    end
    if (issue) begin
      rd_data_q <= mem[rd_ptr_q[STORE_AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign verdict_o   = verdict_q;
  assign frame_len_o = olen_q;
  assign data_o      = data_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire
